/* design/cda_pkg.sv */
`timescale 1ns / 1ps

package cda_pkg;

  // field widths
  localparam int unsigned YearBits  = 16;
  localparam int unsigned MonthBits = 4;
  localparam int unsigned DayBits   = 5;
  localparam int unsigned OpBits    = 4;
  localparam int unsigned CountBits = 15;
  // remaining day count, up to 7 times the largest count
  localparam int unsigned DaysBits  = 18;
  localparam int unsigned PcBits    = 5;

  // reciprocal of 25 scaled by 2^16, rounded down
  localparam int unsigned RecipBits = 12;
  localparam logic [RecipBits-1:0] Recip25 = 12'd2621;

  typedef logic [PcBits-1:0] pc_t;

  // opcodes
  localparam logic [OpBits-1:0] OpDay        = 4'd0;
  localparam logic [OpBits-1:0] OpWeek       = 4'd1;
  localparam logic [OpBits-1:0] OpWeeks      = 4'd2;
  localparam logic [OpBits-1:0] OpMonth      = 4'd3;
  localparam logic [OpBits-1:0] OpMonths     = 4'd4;
  localparam logic [OpBits-1:0] OpYearClamp  = 4'd5;
  localparam logic [OpBits-1:0] OpYears      = 4'd6;
  localparam logic [OpBits-1:0] OpDecade     = 4'd7;
  localparam logic [OpBits-1:0] OpDecades    = 4'd8;
  localparam logic [OpBits-1:0] OpCentury    = 4'd9;
  localparam logic [OpBits-1:0] OpMillennium = 4'd10;

  localparam logic [MonthBits-1:0] MonthJan = 4'd1;
  localparam logic [MonthBits-1:0] MonthFeb = 4'd2;
  localparam logic [MonthBits-1:0] MonthDec = 4'd12;

  localparam logic [DayBits-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // microcode addresses
  localparam pc_t PcIdle    = pc_t'(0);
  localparam pc_t PcWait1   = pc_t'(1);
  localparam pc_t PcWait2   = pc_t'(2);
  localparam pc_t PcWait3   = pc_t'(3);
  localparam pc_t PcCheck   = pc_t'(4);
  localparam pc_t PcDisp    = pc_t'(5);
  localparam pc_t PcDay     = pc_t'(6);
  localparam pc_t PcDayNext = pc_t'(7);
  localparam pc_t PcDayAdd  = pc_t'(8);
  localparam pc_t PcMon     = pc_t'(9);
  localparam pc_t PcMonStep = pc_t'(10);
  localparam pc_t PcMonClmp = pc_t'(11);
  localparam pc_t PcYInc    = pc_t'(12);
  localparam pc_t PcYWait1  = pc_t'(13);
  localparam pc_t PcYWait2  = pc_t'(14);
  localparam pc_t PcYWait3  = pc_t'(15);
  localparam pc_t PcYClamp  = pc_t'(16);
  localparam pc_t PcYAdd    = pc_t'(17);
  localparam pc_t PcFin     = pc_t'(18);
  localparam pc_t PcDayWait = pc_t'(19);

  typedef enum logic [2:0] {
    DpNop,
    DpCheck,
    DpDayNext,
    DpDayAdd,
    DpMonStep,
    DpClamp,
    DpYearInc,
    DpYearAdd
  } dp_op_e;

  typedef enum logic [2:0] {
    CondNone,
    CondAlways,
    CondBad,
    CondDisp,
    CondNFits,
    CondCntZero
  } cond_e;

  typedef struct packed {
    dp_op_e dp_op;
    cond_e  cond;
    pc_t    target;
    logic   fin;
  } uword_t;

  typedef struct packed {
    logic   load;
    dp_op_e dp_op;
  } dp_ctrl_t;

  typedef struct packed {
    logic              bad;
    logic              n_fits;
    logic              cnt_zero;
    logic [OpBits-1:0] opc;
  } dp_stat_t;

  // month length, zero for a month outside 1..12
  function automatic logic [DayBits-1:0] days_in(logic [MonthBits-1:0] m, logic lp);
    logic [DayBits-1:0] len;
    if (m == '0 || m > MonthDec) begin
      len = '0;
    end else if (m == MonthFeb) begin
      len = lp ? 5'd29 : 5'd28;
    end else begin
      len = MonthLen[m - MonthJan];
    end
    return len;
  endfunction

  // entry point of each opcode's routine
  function automatic pc_t op_entry(logic [OpBits-1:0] op);
    pc_t pc;
    unique case (op) inside
      OpDay, OpWeek, OpWeeks: pc = PcDay;
      OpMonth, OpMonths:      pc = PcMon;
      OpYearClamp:            pc = PcYInc;
      OpYears, OpDecade, OpDecades, OpCentury, OpMillennium: pc = PcYAdd;
      default:                pc = PcFin;
    endcase
    return pc;
  endfunction

  // control store
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    w = '{dp_op: DpNop, cond: CondNone, target: PcIdle, fin: 1'b0};
    unique case (pc) inside
      // leap flag of the loaded year settles
      PcWait1, PcWait2, PcWait3: begin
      end
      PcCheck: begin
        w.dp_op  = DpCheck;
        w.cond   = CondBad;
        w.target = PcFin;
      end
      PcDisp: begin
        w.cond = CondDisp;
      end
      // day loop: one month per three-step pass, so the leap flag follows a year carry
      PcDay: begin
        w.cond   = CondNFits;
        w.target = PcDayAdd;
      end
      PcDayNext: begin
        w.dp_op  = DpDayNext;
        w.cond   = CondAlways;
        w.target = PcDayWait;
      end
      PcDayWait: begin
        w.cond   = CondAlways;
        w.target = PcDay;
      end
      PcDayAdd: begin
        w.dp_op  = DpDayAdd;
        w.cond   = CondAlways;
        w.target = PcFin;
      end
      // month loop: step then clamp
      PcMon: begin
        w.cond   = CondCntZero;
        w.target = PcFin;
      end
      PcMonStep: begin
        w.dp_op = DpMonStep;
      end
      PcMonClmp: begin
        w.dp_op  = DpClamp;
        w.cond   = CondAlways;
        w.target = PcMon;
      end
      // clamped year step waits for the new leap flag
      PcYInc: begin
        w.dp_op = DpYearInc;
      end
      PcYWait1, PcYWait2, PcYWait3: begin
      end
      PcYClamp: begin
        w.dp_op  = DpClamp;
        w.cond   = CondAlways;
        w.target = PcFin;
      end
      PcYAdd: begin
        w.dp_op  = DpYearAdd;
        w.cond   = CondAlways;
        w.target = PcFin;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/cda_leap.sv */
`timescale 1ns / 1ps

module cda_leap (
  input  logic                         clk_i,
  input  logic [cda_pkg::YearBits-1:0] year_i,
  output logic                         leap_o
);

  localparam int unsigned ProdBits = cda_pkg::YearBits + cda_pkg::RecipBits;
  localparam int unsigned QuotBits = cda_pkg::RecipBits;

  logic [cda_pkg::YearBits-1:0] abs1_q, abs2_q;
  logic [3:0]                   low1_q, low2_q;
  logic [ProdBits-1:0]          prod;
  logic [QuotBits-1:0]          quot_q;
  logic [cda_pkg::YearBits:0]   qx25;
  logic [cda_pkg::YearBits:0]   rem;
  logic [5:0]                   rem6;
  logic                         div25;
  logic                         leap_q;

  // quotient estimate by 25, low by at most one
  assign prod = ProdBits'(abs1_q) * ProdBits'(cda_pkg::Recip25);

  // remainder stays below 50 after the estimate
  assign qx25  = ((cda_pkg::YearBits+1)'(quot_q) << 4) + ((cda_pkg::YearBits+1)'(quot_q) << 3)
               + (cda_pkg::YearBits+1)'(quot_q);
  assign rem   = {1'b0, abs2_q} - qx25;
  assign rem6  = rem[5:0];
  assign div25 = (rem6 == 6'd0) || (rem6 == 6'd25);

  // three stage pipeline: magnitude, product, flag
  always_ff @(posedge clk_i) begin
    abs1_q <= year_i[cda_pkg::YearBits-1] ? (~year_i + 1'b1) : year_i;
    low1_q <= year_i[3:0];
    quot_q <= prod[ProdBits-1 -: QuotBits];
    abs2_q <= abs1_q;
    low2_q <= low1_q;
    leap_q <= (low2_q[1:0] == 2'b00) && (!div25 || (low2_q == 4'd0));
  end

  assign leap_o = leap_q;

endmodule

/* design/cda_dpath.sv */
`timescale 1ns / 1ps

module cda_dpath (
  input  logic                          clk_i,
  input  cda_pkg::dp_ctrl_t             ctrl_i,
  input  logic [cda_pkg::YearBits-1:0]  in_year_i,
  input  logic [cda_pkg::MonthBits-1:0] in_month_i,
  input  logic [cda_pkg::DayBits-1:0]   in_day_i,
  input  logic [cda_pkg::OpBits-1:0]    opcode_i,
  input  logic [cda_pkg::CountBits-1:0] count_i,
  input  logic                          leap_i,
  output cda_pkg::dp_stat_t             stat_o,
  output logic [cda_pkg::YearBits-1:0]  year_o,
  output logic [cda_pkg::MonthBits-1:0] month_o,
  output logic [cda_pkg::DayBits-1:0]   day_o,
  output logic                          bad_o
);

  logic [cda_pkg::YearBits-1:0]  year_q;
  logic [cda_pkg::MonthBits-1:0] month_q;
  logic [cda_pkg::DayBits-1:0]   day_q;
  logic [cda_pkg::OpBits-1:0]    opc_q;
  logic [cda_pkg::CountBits-1:0] cnt_q;
  logic [cda_pkg::DaysBits-1:0]  n_q;
  logic                          bad_q;

  logic [cda_pkg::DayBits-1:0]   len;
  logic [cda_pkg::DayBits-1:0]   rem;
  logic                          bad_now;
  logic [cda_pkg::MonthBits-1:0] month_nxt;
  logic [cda_pkg::YearBits-1:0]  year_nxt;
  logic [cda_pkg::DaysBits-1:0]  n_load;
  logic [cda_pkg::DaysBits-1:0]  cnt_ext;
  logic [cda_pkg::YearBits-1:0]  cnt_y;
  logic [cda_pkg::YearBits-1:0]  addend;

  // month length and room left in the current month
  assign len     = cda_pkg::days_in(month_q, leap_i);
  assign rem     = len - day_q;
  assign bad_now = (len == '0) || (day_q == '0) || (day_q > len);

  // one month forward, year carries out of december
  always_comb begin
    if (month_q == cda_pkg::MonthDec) begin
      month_nxt = cda_pkg::MonthJan;
      year_nxt  = year_q + 1'b1;
    end else begin
      month_nxt = month_q + 1'b1;
      year_nxt  = year_q;
    end
  end

  // day count of the day and week opcodes
  assign cnt_ext = cda_pkg::DaysBits'(count_i);
  always_comb begin
    unique case (opcode_i)
      cda_pkg::OpDay:   n_load = cda_pkg::DaysBits'(1);
      cda_pkg::OpWeek:  n_load = cda_pkg::DaysBits'(7);
      cda_pkg::OpWeeks: n_load = (cnt_ext << 3) - cnt_ext;
      default:          n_load = '0;
    endcase
  end

  // year addend of the plain year opcodes
  assign cnt_y = cda_pkg::YearBits'(cnt_q);
  always_comb begin
    unique case (opc_q)
      cda_pkg::OpYears:      addend = cnt_y;
      cda_pkg::OpDecade:     addend = cda_pkg::YearBits'(10);
      cda_pkg::OpDecades:    addend = (cnt_y << 3) + (cnt_y << 1);
      cda_pkg::OpCentury:    addend = cda_pkg::YearBits'(100);
      cda_pkg::OpMillennium: addend = cda_pkg::YearBits'(1000);
      default:               addend = '0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      year_q  <= in_year_i;
      month_q <= in_month_i;
      day_q   <= in_day_i;
      opc_q   <= opcode_i;
      cnt_q   <= (opcode_i == cda_pkg::OpMonth) ? cda_pkg::CountBits'(1) : count_i;
      n_q     <= n_load;
      bad_q   <= 1'b0;
    end else begin
      unique case (ctrl_i.dp_op)
        cda_pkg::DpCheck: begin
          bad_q <= bad_now;
        end
        cda_pkg::DpDayNext: begin
          n_q     <= n_q - (cda_pkg::DaysBits'(rem) + 1'b1);
          day_q   <= cda_pkg::DayBits'(1);
          month_q <= month_nxt;
          year_q  <= year_nxt;
        end
        cda_pkg::DpDayAdd: begin
          day_q <= day_q + n_q[cda_pkg::DayBits-1:0];
        end
        cda_pkg::DpMonStep: begin
          month_q <= month_nxt;
          year_q  <= year_nxt;
          cnt_q   <= cnt_q - 1'b1;
        end
        cda_pkg::DpClamp: begin
          if (day_q > len) begin
            day_q <= len;
          end
        end
        cda_pkg::DpYearInc: begin
          year_q <= year_q + 1'b1;
        end
        cda_pkg::DpYearAdd: begin
          year_q <= year_q + addend;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.bad      = bad_now;
  assign stat_o.n_fits   = (n_q <= cda_pkg::DaysBits'(rem));
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.opc      = opc_q;

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;
  assign bad_o   = bad_q;

endmodule

/* design/cda_seq.sv */
`timescale 1ns / 1ps

module cda_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  cda_pkg::dp_stat_t  stat_i,
  output cda_pkg::dp_ctrl_t  ctrl_o,
  output logic               busy_o,
  output logic               done_o
);

  cda_pkg::pc_t   pc_q, pc_d;
  logic           busy_q, busy_d;
  cda_pkg::uword_t word;
  logic           accept;
  logic           taken;

  assign word   = cda_pkg::ucode_rom(pc_q);
  assign accept = start_i && !busy_q;

  // jump condition
  always_comb begin
    unique case (word.cond)
      cda_pkg::CondAlways:  taken = 1'b1;
      cda_pkg::CondBad:     taken = stat_i.bad;
      cda_pkg::CondDisp:    taken = 1'b1;
      cda_pkg::CondNFits:   taken = stat_i.n_fits;
      cda_pkg::CondCntZero: taken = stat_i.cnt_zero;
      default:              taken = 1'b0;
    endcase
  end

  // step counter and busy flag
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = cda_pkg::PcWait1;
      end
    end else if (word.fin) begin
      busy_d = 1'b0;
      pc_d   = cda_pkg::PcIdle;
    end else if (taken) begin
      pc_d = (word.cond == cda_pkg::CondDisp) ? cda_pkg::op_entry(stat_i.opc) : word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= cda_pkg::PcIdle;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign ctrl_o.load  = accept;
  assign ctrl_o.dp_op = busy_q ? word.dp_op : cda_pkg::DpNop;
  assign busy_o       = busy_q;
  assign done_o       = busy_q && word.fin;

endmodule

/* design/calendar_date_advance.sv */
`timescale 1ns / 1ps
// sequence: after accept the date waits for its leap flag, is checked, then dispatched by opcode;
// day and week steps walk one month per pass, month steps step and clamp one month per pass,
// clamped year steps wait for the new leap flag; bad dates, unknown opcodes go to the result beat
// throughput: one item at a time, busy high from accept through the result beat, next accept
// in the cycle after it; receiver cannot stall
// reset clears the sequencer only; no memory, no clearing pass

module calendar_date_advance (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [cda_pkg::YearBits-1:0]  in_year_i,
  input  logic        [cda_pkg::MonthBits-1:0] in_month_i,
  input  logic        [cda_pkg::DayBits-1:0]   in_day_i,
  input  logic        [cda_pkg::OpBits-1:0]    opcode_i,
  input  logic        [cda_pkg::CountBits-1:0] count_i,
  output logic                                 done_o,
  output logic signed [cda_pkg::YearBits-1:0]  out_year_o,
  output logic        [cda_pkg::MonthBits-1:0] out_month_o,
  output logic        [cda_pkg::DayBits-1:0]   out_day_o,
  output logic                                 bad_date_o
);

  cda_pkg::dp_ctrl_t             ctrl;
  cda_pkg::dp_stat_t             stat;
  logic [cda_pkg::YearBits-1:0]  year;
  logic                          leap;

  // microcode sequencer
  cda_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // date registers and step logic
  cda_dpath u_dpath (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .in_year_i  ($unsigned(in_year_i)),
    .in_month_i (in_month_i),
    .in_day_i   (in_day_i),
    .opcode_i   (opcode_i),
    .count_i    (count_i),
    .leap_i     (leap),
    .stat_o     (stat),
    .year_o     (year),
    .month_o    (out_month_o),
    .day_o      (out_day_o),
    .bad_o      (bad_date_o)
  );

  // leap flag of the current year, registered through magnitude, product and flag stages
  cda_leap u_leap (
    .clk_i  (clk_i),
    .year_i (year),
    .leap_o (leap)
  );

  assign out_year_o = $signed(year);

endmodule
